/* rtl/pfe_pkg.sv */
`default_nettype none

package pfe_pkg;

  localparam int SQ_SIDE = 5;
  localparam int SQ_SIZE = SQ_SIDE * SQ_SIDE;
  localparam int ALPHA   = 26;

  localparam logic [1:0] REQ_KEY    = 2'd0;
  localparam logic [1:0] REQ_FINISH = 2'd1;
  localparam logic [1:0] REQ_TEXT   = 2'd2;
  localparam logic [1:0] REQ_END    = 2'd3;

  localparam logic [4:0] LET_I = 5'd8;
  localparam logic [4:0] LET_J = 5'd9;
  localparam logic [4:0] LET_X = 5'd23;

  localparam logic [4:0] LAST_LETTER = 5'(ALPHA - 1);
  localparam logic [4:0] FULL_COUNT  = 5'(SQ_SIZE);
  localparam logic [2:0] LAST_INDEX  = 3'(SQ_SIDE - 1);

  typedef logic [4:0] letter_t;
  typedef logic [4:0] pos_t;
  typedef logic [2:0] coord_t;

  function automatic coord_t pos_row(input pos_t p);
    coord_t r;
    if (p >= 5'(4 * SQ_SIDE)) r = 3'd4;
    else if (p >= 5'(3 * SQ_SIDE)) r = 3'd3;
    else if (p >= 5'(2 * SQ_SIDE)) r = 3'd2;
    else if (p >= 5'(SQ_SIDE)) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  function automatic pos_t row_base(input coord_t r);
    return {r, 2'b00} + {2'b00, r};
  endfunction

  function automatic coord_t pos_col(input pos_t p);
    pos_t d;
    d = p - row_base(pos_row(p));
    return d[2:0];
  endfunction

  function automatic pos_t pos_at(input coord_t r, input coord_t c);
    return row_base(r) + {2'b00, c};
  endfunction

  function automatic coord_t step_wrap(input coord_t v);
    return (v == LAST_INDEX) ? 3'd0 : 3'(v + 3'd1);
  endfunction

endpackage

`default_nettype wire

/* rtl/playfair_digraph_encryptor.sv */
`default_nettype none
// Key letter: placed in the accepting cycle. Finish key: an accept, then a walk over the alphabet.
// A plaintext or end-of-message beat that closes a pair walks the states RDA, RDB, CALC, SQX,
// SQY, EMIT1 and EMIT2; its cipher letters leave from EMIT1 and EMIT2; in_ready returns in idle.
// The serial reads of the single-port place table and key square set that sequence of states.
// rst_n (synchronous) clears the control state; the key square and place table stay unset.
module playfair_digraph_encryptor (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [1:0] in_req_type,
  input  wire  [4:0] in_letter,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [4:0] out_cipher_letter,
  output logic       out_pair_last,
  output logic       out_message_last
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_FILL, ST_RDA, ST_RDB, ST_CALC, ST_SQX, ST_SQY, ST_EMIT1, ST_EMIT2
  } state_t;

  state_t                  state_r;
  logic [pfe_pkg::ALPHA-1:0] taken_r;
  logic [4:0]              fill_count_r;
  logic                    square_ready_r;
  pfe_pkg::letter_t        held_letter_r;
  logic                    held_valid_r;
  logic [4:0]              fill_idx_r;
  pfe_pkg::letter_t        a_r;
  pfe_pkg::letter_t        b_r;
  logic                    mlast_r;
  pfe_pkg::pos_t           pa_r;
  pfe_pkg::pos_t           xa_r;
  pfe_pkg::pos_t           ya_r;
  pfe_pkg::letter_t        letter_x_r;

  pfe_pkg::letter_t        square_mem [pfe_pkg::SQ_SIZE];
  pfe_pkg::pos_t           place_mem  [pfe_pkg::ALPHA];
  pfe_pkg::pos_t           place_rd_r;
  pfe_pkg::letter_t        sq_rd_r;

  logic             accept;
  pfe_pkg::letter_t l_in;
  logic             l_ok;
  logic [4:0]       key_fill;
  logic             key_taken;
  logic [pfe_pkg::ALPHA-1:0] taken_key_nxt;
  logic             wr_en;
  pfe_pkg::letter_t wr_letter;
  pfe_pkg::pos_t    wr_pos;
  pfe_pkg::letter_t place_raddr;
  pfe_pkg::pos_t    sq_raddr;
  logic             out_free;
  pfe_pkg::coord_t  r1, c1, r2, c2;
  pfe_pkg::pos_t    xa_calc, ya_calc;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign l_in     = (in_letter == pfe_pkg::LET_J) ? pfe_pkg::LET_I : in_letter;
  assign l_ok     = (l_in <= pfe_pkg::LAST_LETTER);
  assign out_free = !out_valid || out_ready;

  // A key letter after a finished square restarts the key, so it sees an empty square.
  assign key_fill  = square_ready_r ? 5'd0 : fill_count_r;
  assign key_taken = square_ready_r ? 1'b0 : (l_ok && taken_r[l_in]);

  always_comb begin
    wr_en     = 1'b0;
    wr_letter = l_in;
    wr_pos    = key_fill;
    if (state_r == ST_FILL) begin
      wr_letter = fill_idx_r;
      wr_pos    = fill_count_r;
      wr_en     = (fill_idx_r != pfe_pkg::LET_J) && !taken_r[fill_idx_r]
                  && (fill_count_r < pfe_pkg::FULL_COUNT);
    end else if (accept && in_req_type == pfe_pkg::REQ_KEY && l_ok) begin
      wr_en = !key_taken && (key_fill < pfe_pkg::FULL_COUNT);
    end
  end

  always_comb begin
    taken_key_nxt = square_ready_r ? '0 : taken_r;
    if (wr_en) begin
      taken_key_nxt[wr_letter] = 1'b1;
    end
  end

  assign place_raddr = (state_r == ST_RDA) ? a_r : b_r;
  assign sq_raddr    = (state_r == ST_SQX) ? xa_r : ya_r;

  always_comb begin
    r1 = pfe_pkg::pos_row(pa_r);
    c1 = pfe_pkg::pos_col(pa_r);
    r2 = pfe_pkg::pos_row(place_rd_r);
    c2 = pfe_pkg::pos_col(place_rd_r);
    if (r1 == r2) begin
      xa_calc = pfe_pkg::pos_at(r1, pfe_pkg::step_wrap(c1));
      ya_calc = pfe_pkg::pos_at(r2, pfe_pkg::step_wrap(c2));
    end else if (c1 == c2) begin
      xa_calc = pfe_pkg::pos_at(pfe_pkg::step_wrap(r1), c1);
      ya_calc = pfe_pkg::pos_at(pfe_pkg::step_wrap(r2), c2);
    end else begin
      xa_calc = pfe_pkg::pos_at(r1, c2);
      ya_calc = pfe_pkg::pos_at(r2, c1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      square_mem[wr_pos]   <= wr_letter;
      place_mem[wr_letter] <= wr_pos;
    end
    place_rd_r <= place_mem[place_raddr];
    sq_rd_r    <= square_mem[sq_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      taken_r          <= '0;
      fill_count_r     <= '0;
      square_ready_r   <= 1'b0;
      held_letter_r    <= '0;
      held_valid_r     <= 1'b0;
      fill_idx_r       <= '0;
      out_valid        <= 1'b0;
    end else begin
      // The emit states load the next beat themselves when the current one drains.
      if (out_valid && out_ready && state_r != ST_EMIT1 && state_r != ST_EMIT2) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_req_type)
              pfe_pkg::REQ_KEY: begin
                if (l_ok) begin
                  if (square_ready_r) begin
                    square_ready_r <= 1'b0;
                    held_valid_r   <= 1'b0;
                    held_letter_r  <= '0;
                  end
                  fill_count_r <= wr_en ? 5'(key_fill + 5'd1) : key_fill;
                  taken_r      <= taken_key_nxt;
                end
              end
              pfe_pkg::REQ_FINISH: begin
                if (!square_ready_r) begin
                  fill_idx_r <= '0;
                  state_r    <= ST_FILL;
                end
              end
              pfe_pkg::REQ_TEXT: begin
                if (l_ok && square_ready_r) begin
                  if (!held_valid_r) begin
                    held_letter_r <= l_in;
                    held_valid_r  <= 1'b1;
                  end else begin
                    a_r          <= held_letter_r;
                    b_r          <= l_in;
                    mlast_r      <= 1'b0;
                    held_valid_r <= 1'b0;
                    state_r      <= ST_RDA;
                  end
                end
              end
              pfe_pkg::REQ_END: begin
                if (square_ready_r && held_valid_r) begin
                  a_r          <= held_letter_r;
                  b_r          <= pfe_pkg::LET_X;
                  mlast_r      <= 1'b1;
                  held_valid_r <= 1'b0;
                  state_r      <= ST_RDA;
                end
              end
              default: ;
            endcase
          end
        end
        ST_FILL: begin
          if (wr_en) begin
            taken_r[fill_idx_r] <= 1'b1;
            fill_count_r        <= 5'(fill_count_r + 5'd1);
          end
          if (fill_idx_r == pfe_pkg::LAST_LETTER) begin
            square_ready_r <= 1'b1;
            state_r        <= ST_IDLE;
          end else begin
            fill_idx_r <= 5'(fill_idx_r + 5'd1);
          end
        end
        ST_RDA: state_r <= ST_RDB;
        ST_RDB: begin
          pa_r    <= place_rd_r;
          state_r <= ST_CALC;
        end
        ST_CALC: begin
          xa_r    <= xa_calc;
          ya_r    <= ya_calc;
          state_r <= ST_SQX;
        end
        ST_SQX: state_r <= ST_SQY;
        ST_SQY: begin
          letter_x_r <= sq_rd_r;
          state_r    <= ST_EMIT1;
        end
        ST_EMIT1: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            out_cipher_letter <= letter_x_r;
            out_pair_last     <= 1'b0;
            out_message_last  <= 1'b0;
            state_r           <= ST_EMIT2;
          end
        end
        ST_EMIT2: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            out_cipher_letter <= sq_rd_r;
            out_pair_last     <= 1'b1;
            out_message_last  <= mlast_r;
            state_r           <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/pfe_checker.sv */
`default_nettype none

module pfe_sva (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire [1:0] in_req_type,
  input wire       out_valid,
  input wire       out_ready,
  input wire [4:0] out_cipher_letter,
  input wire       out_pair_last,
  input wire       out_message_last
);

  // A stalled result beat holds its letter and flags.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cipher_letter)
      && $stable(out_pair_last) && $stable(out_message_last))
    else $error("result beat changed while stalled");

  // The end-of-message flag only marks the closing letter of a digraph.
  a_msg_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_last |-> out_pair_last)
    else $error("message_last without pair_last");

  // Cipher letters come from the square, which never holds J or an out-of-range code.
  a_letter_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cipher_letter != pfe_pkg::LET_J
      && out_cipher_letter <= pfe_pkg::LAST_LETTER)
    else $error("cipher letter out of alphabet");

  // A key letter is placed in the accepting cycle, so the block stays ready.
  a_key_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == pfe_pkg::REQ_KEY |=> in_ready)
    else $error("key letter stalled the input");

  // The second letter of a digraph follows directly on the first one's acceptance.
  a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_pair_last |=> out_valid && out_pair_last)
    else $error("digraph second letter missing");

endmodule

bind playfair_digraph_encryptor pfe_sva u_pfe_sva (.*);

`default_nettype wire

/* bench/pfe_checker.sv */
module pfe_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_ready,
  input  wire  [1:0] in_req_type,
  input  wire  [4:0] in_letter,
  input  wire        out_valid,
  input  wire        out_ready,
  input  wire  [4:0] out_cipher_letter,
  input  wire        out_pair_last,
  input  wire        out_message_last,
  output int         fail_count,
  output int         cipher_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pfe_pkg::letter_t cipher;
    logic             pair_last;
    logic             message_last;
  } cipher_beat_t;

  // Shadow copy of the key square and the encryption state.
  pfe_pkg::letter_t key_square [pfe_pkg::SQ_SIZE];
  pfe_pkg::pos_t    square_pos [pfe_pkg::ALPHA];
  logic             used_letter [pfe_pkg::ALPHA];
  int               filled;
  logic             square_done;
  pfe_pkg::letter_t first_letter;
  logic             first_held;

  cipher_beat_t cipher_due [$];

  function automatic void place_key_letter(input pfe_pkg::letter_t l);
    if (l >= pfe_pkg::ALPHA || used_letter[l] || filled >= pfe_pkg::SQ_SIZE) return;
    key_square[filled] = l;
    square_pos[l] = pfe_pkg::pos_t'(filled);
    used_letter[l] = 1'b1;
    filled++;
  endfunction

  function automatic void encipher_pair(input pfe_pkg::letter_t a,
                                        input pfe_pkg::letter_t b,
                                        input logic at_end);
    int pa, pb, r1, c1, r2, c2;
    pfe_pkg::letter_t x, y;
    pa = int'(square_pos[a]);
    pb = int'(square_pos[b]);
    r1 = pa / pfe_pkg::SQ_SIDE;
    c1 = pa % pfe_pkg::SQ_SIDE;
    r2 = pb / pfe_pkg::SQ_SIDE;
    c2 = pb % pfe_pkg::SQ_SIDE;
    if (r1 == r2) begin
      x = key_square[r1 * pfe_pkg::SQ_SIDE + (c1 + 1) % pfe_pkg::SQ_SIDE];
      y = key_square[r2 * pfe_pkg::SQ_SIDE + (c2 + 1) % pfe_pkg::SQ_SIDE];
    end else if (c1 == c2) begin
      x = key_square[((r1 + 1) % pfe_pkg::SQ_SIDE) * pfe_pkg::SQ_SIDE + c1];
      y = key_square[((r2 + 1) % pfe_pkg::SQ_SIDE) * pfe_pkg::SQ_SIDE + c2];
    end else begin
      x = key_square[r1 * pfe_pkg::SQ_SIDE + c2];
      y = key_square[r2 * pfe_pkg::SQ_SIDE + c1];
    end
    cipher_due.push_back('{cipher: x, pair_last: 1'b0, message_last: 1'b0});
    cipher_due.push_back('{cipher: y, pair_last: 1'b1, message_last: at_end});
  endfunction

  function automatic void clear_key();
    foreach (used_letter[i]) used_letter[i] = 1'b0;
    filled = 0;
    square_done = 1'b0;
    first_held = 1'b0;
    first_letter = '0;
  endfunction

  function automatic void predict_beat(input logic [1:0] req, input pfe_pkg::letter_t l_in);
    pfe_pkg::letter_t l;
    l = (l_in == pfe_pkg::LET_J) ? pfe_pkg::LET_I : l_in;
    case (req)
      pfe_pkg::REQ_KEY: begin
        if (l < pfe_pkg::ALPHA) begin
          if (square_done) clear_key();
          place_key_letter(l);
        end
      end
      pfe_pkg::REQ_FINISH: begin
        if (!square_done) begin
          for (int i = 0; i < pfe_pkg::ALPHA; i++)
            if (pfe_pkg::letter_t'(i) != pfe_pkg::LET_J)
              place_key_letter(pfe_pkg::letter_t'(i));
          square_done = 1'b1;
        end
      end
      pfe_pkg::REQ_TEXT: begin
        if (l < pfe_pkg::ALPHA && square_done) begin
          if (!first_held) begin
            first_letter = l;
            first_held = 1'b1;
          end else begin
            first_held = 1'b0;
            encipher_pair(first_letter, l, 1'b0);
          end
        end
      end
      pfe_pkg::REQ_END: begin
        if (square_done && first_held) begin
          first_held = 1'b0;
          encipher_pair(first_letter, pfe_pkg::LET_X, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    cipher_beat_t want;
    if (!rst_n) begin
      clear_key();
      cipher_due.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (cipher_due.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected output beat: cipher %0d pair_last %0b message_last %0b",
                     out_cipher_letter, out_pair_last, out_message_last);
          fail_count++;
        end else begin
          want = cipher_due.pop_front();
          if (out_cipher_letter !== want.cipher || out_pair_last !== want.pair_last ||
              out_message_last !== want.message_last) begin
            if (fail_count < 10)
              $display("mismatch: cipher %0d/%0d pair_last %0b/%0b message_last %0b/%0b",
                       want.cipher, out_cipher_letter, want.pair_last, out_pair_last,
                       want.message_last, out_message_last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_beat(in_req_type, in_letter);
    end
    cipher_pending = cipher_due.size();
  end

endmodule

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CALM_FROM = 2500;
  localparam int CALM_TO   = 3500;
  localparam int HOLD_FROM = 1500;
  localparam int HOLD_LEN  = 300;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_req_type = pfe_pkg::REQ_KEY;
  logic [4:0] in_letter = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [4:0] out_cipher_letter;
  logic       out_pair_last;
  logic       out_message_last;
  int         fail_count;
  int         cipher_pending;
  int         cyc = 0;
  int         beats_sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cyc <= cyc + 1;

  playfair_digraph_encryptor u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_letter        (in_letter),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cipher_letter(out_cipher_letter),
    .out_pair_last    (out_pair_last),
    .out_message_last (out_message_last)
  );

  pfe_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_letter        (in_letter),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cipher_letter(out_cipher_letter),
    .out_pair_last    (out_pair_last),
    .out_message_last (out_message_last),
    .fail_count       (fail_count),
    .cipher_pending   (cipher_pending)
  );

  function automatic logic calm();
    return cyc >= CALM_FROM && cyc < CALM_TO;
  endfunction

  // Mostly real letters, now and then a code past Z.
  function automatic logic [4:0] pick_letter();
    if ($urandom_range(99) < 10) return 5'($urandom_range(31, pfe_pkg::ALPHA));
    return 5'($urandom_range(pfe_pkg::ALPHA - 1));
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [1:0] req, input logic [4:0] l);
    while (!calm() && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_letter <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  // Receiver: random stalls, one long hold-off, and a stall-free stretch.
  initial begin
    int rcv_cyc;
    rcv_cyc = 0;
    forever begin
      @(negedge clk);
      rcv_cyc++;
      if (rcv_cyc >= HOLD_FROM && rcv_cyc < HOLD_FROM + HOLD_LEN) out_ready <= 1'b0;
      else if (calm()) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 23);
    end
  end

  initial begin
    #(4 * 400000);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int n_key, n_text;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Text and end of message before any square exists are dropped.
    send_beat(pfe_pkg::REQ_TEXT, 5'd0);
    send_beat(pfe_pkg::REQ_END, 5'd0);
    // Key with a repeat, a J folded to I and an out-of-range letter.
    send_beat(pfe_pkg::REQ_KEY, 5'd15);
    send_beat(pfe_pkg::REQ_KEY, 5'd11);
    send_beat(pfe_pkg::REQ_KEY, 5'd0);
    send_beat(pfe_pkg::REQ_KEY, 5'd24);
    send_beat(pfe_pkg::REQ_KEY, 5'd5);
    send_beat(pfe_pkg::REQ_KEY, 5'd0);
    send_beat(pfe_pkg::REQ_KEY, pfe_pkg::LET_J);
    send_beat(pfe_pkg::REQ_KEY, 5'd31);
    send_beat(pfe_pkg::REQ_KEY, 5'd17);
    send_beat(pfe_pkg::REQ_FINISH, 5'd0);
    send_beat(pfe_pkg::REQ_FINISH, 5'd31);
    send_beat(pfe_pkg::REQ_END, 5'd0);
    // Same row, same column, rectangle, equal letters, plaintext J.
    send_beat(pfe_pkg::REQ_TEXT, 5'd15);
    send_beat(pfe_pkg::REQ_TEXT, 5'd11);
    send_beat(pfe_pkg::REQ_TEXT, 5'd15);
    send_beat(pfe_pkg::REQ_TEXT, 5'd8);
    send_beat(pfe_pkg::REQ_TEXT, 5'd11);
    send_beat(pfe_pkg::REQ_TEXT, 5'd3);
    send_beat(pfe_pkg::REQ_TEXT, 5'd19);
    send_beat(pfe_pkg::REQ_TEXT, 5'd19);
    send_beat(pfe_pkg::REQ_TEXT, pfe_pkg::LET_J);
    send_beat(pfe_pkg::REQ_TEXT, 5'd25);
    // Odd letter padded with X, then a key letter that restarts the key.
    send_beat(pfe_pkg::REQ_TEXT, 5'd26);
    send_beat(pfe_pkg::REQ_TEXT, 5'd25);
    send_beat(pfe_pkg::REQ_END, 5'd0);
    send_beat(pfe_pkg::REQ_KEY, 5'd25);

    while (beats_sent < 870) begin
      if ($urandom_range(99) < 85) begin
        n_key = $urandom_range(12);
        n_text = $urandom_range(30, 1);
        for (int i = 0; i < n_key; i++) send_beat(pfe_pkg::REQ_KEY, pick_letter());
        send_beat(pfe_pkg::REQ_FINISH, 5'($urandom_range(31)));
        for (int i = 0; i < n_text; i++) begin
          if ($urandom_range(99) < 4) send_beat(2'($urandom_range(3)), 5'($urandom_range(31)));
          else send_beat(pfe_pkg::REQ_TEXT, pick_letter());
        end
        if ($urandom_range(99) < 90) send_beat(pfe_pkg::REQ_END, 5'($urandom_range(31)));
      end else begin
        send_beat(2'($urandom_range(3)), 5'($urandom_range(31)));
      end
    end
    in_valid <= 1'b0;

    while (cipher_pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
